// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence a fixed number of cycles later
`define SFD_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

  // sample and arithmetic widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DAMP_W     = SAMPLE_W + 2;
  localparam int unsigned SUM_W      = SAMPLE_W + 2;
  localparam int unsigned TAP_W      = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FB_SHIFT   = 18;
  localparam int unsigned WET_SHIFT  = 16;
  localparam int unsigned PROD_FB_W  = DAMP_W + GAIN_W + 1;
  localparam int unsigned PROD_WET_W = SAMPLE_W + GAIN_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // defaults
  localparam int unsigned LINE_FRAMES_DFLT = 17640;
  localparam int unsigned TAP_LEFT_RST     = 13230;
  localparam int unsigned TAP_RIGHT_RST    = 16317;
  localparam int unsigned FB_GAIN_RST      = 23593;
  localparam int unsigned WET_GAIN_RST     = 27525;

  // output queue, power of two
  localparam int unsigned OFIFO_DEPTH = 8;
  localparam int unsigned OFIFO_LVL_W = $clog2(OFIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DAMP_W-1:0]   damp_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  localparam sum_t SUM_MAX = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam sum_t SUM_MIN = ~SUM_MAX;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_LEFT  = 'd0,
    REG_TAP_RIGHT = 'd1,
    REG_FB_GAIN   = 'd2,
    REG_WET_GAIN  = 'd3
  } cfg_reg_t;

  typedef enum logic {
    CFG_IDLE,
    CFG_REDUCE
  } cfg_state_t;

  // live settings handed to the datapath
  typedef struct packed {
    logic [TAP_W-1:0]  tap_left;
    logic [TAP_W-1:0]  tap_right;
    logic [GAIN_W-1:0] fb_gain;
    logic [GAIN_W-1:0] wet_gain;
    logic              busy;
  } cfg_t;

  // finished frame pushed into the output queue
  typedef struct packed {
    logic    vld;
    sample_t mix_left;
    sample_t mix_right;
  } res_t;

  // clamp to the sample range
  function automatic sample_t sat_sample(input sum_t x);
    sum_t r;
    r = x;
    if (x > SUM_MAX) begin
      r = SUM_MAX;
    end else if (x < SUM_MIN) begin
      r = SUM_MIN;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  // one-pole lowpass, quarter coefficient, floor rounding
  function automatic damp_t damp_step(input damp_t d, input sample_t e);
    logic signed [DAMP_W+1:0] dw;
    logic signed [DAMP_W+1:0] ew;
    logic signed [DAMP_W+1:0] neg;
    logic signed [DAMP_W+1:0] sum;
    dw  = d;
    ew  = e;
    neg = -dw;
    sum = dw + ew + (neg >>> 2);
    return sum[DAMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfd_in_if.sv =====
`default_nettype none

interface sfd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sfd_pkg::SAMPLE_W-1:0] dry_left;
  logic signed [sfd_pkg::SAMPLE_W-1:0] dry_right;

  modport source (output valid, output dry_left, output dry_right, input ready);
  modport sink   (input valid, input dry_left, input dry_right, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfd_out_if.sv =====
`default_nettype none

interface sfd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sfd_pkg::SAMPLE_W-1:0] mix_left;
  logic signed [sfd_pkg::SAMPLE_W-1:0] mix_right;

  modport source (output valid, output mix_left, output mix_right, input ready);
  modport sink   (input valid, input mix_left, input mix_right, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfd_cfg_if.sv =====
`default_nettype none

interface sfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sfd_pkg::CFG_IDX_W-1:0]     index;
  logic [sfd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfd_line.sv =====
`default_nettype none

module sfd_line #(
  parameter  int unsigned DEPTH = 2,
  parameter  int unsigned WIDTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port, read returns old data on collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_cfg.sv =====
`default_nettype none

module sfd_cfg #(
  parameter int unsigned LINE_FRAMES = sfd_pkg::LINE_FRAMES_DFLT
) (
  input  logic          clk,
  input  logic          rst_n,
  sfd_cfg_if.sink       cfg_chan,
  output sfd_pkg::cfg_t cfg_o
);
  import sfd_pkg::*;

  localparam int unsigned RED_STEPS = 3;
  localparam int unsigned CNT_W  = $clog2(RED_STEPS);
  localparam int unsigned LINE_W = $clog2(LINE_FRAMES + 1);
  localparam int unsigned CMP_W  = (TAP_W + 1 > LINE_W) ? TAP_W + 1 : LINE_W;
  localparam int unsigned PROD_W = TAP_W + CMP_W;
  localparam logic [CMP_W-1:0] LINE_K = CMP_W'(LINE_FRAMES);
  // floor of 2^TAP_W over the line length, quotient estimate is low by at most one
  localparam logic [TAP_W-1:0] RECIP_K = TAP_W'((2 ** TAP_W) / LINE_FRAMES);
  localparam logic [TAP_W-1:0] TAP_L_RST = TAP_W'(TAP_LEFT_RST % LINE_FRAMES);
  localparam logic [TAP_W-1:0] TAP_R_RST = TAP_W'(TAP_RIGHT_RST % LINE_FRAMES);

  cfg_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [TAP_W-1:0]  num_r;
  logic [TAP_W-1:0]  quot_r;
  logic [TAP_W-1:0]  rest_r;
  logic              dst_right_r;
  logic [TAP_W-1:0]  tap_l_r;
  logic [TAP_W-1:0]  tap_r_r;
  logic [GAIN_W-1:0] fb_r;
  logic [GAIN_W-1:0] wet_r;

  logic              wr_fire;
  logic              wr_tap_l, wr_tap_r, wr_fb, wr_wet;
  logic              busy;
  logic [PROD_W-1:0] quot_prod;
  logic [PROD_W-1:0] back_prod;
  logic [CMP_W-1:0]  rest_ext;
  logic [TAP_W-1:0]  rem_nxt;
  logic              last_step;

  assign wr_fire = cfg_chan.valid && cfg_chan.ready;

  // register decode, unknown indexes are dropped
  always_comb begin
    wr_tap_l = 1'b0;
    wr_tap_r = 1'b0;
    wr_fb    = 1'b0;
    wr_wet   = 1'b0;
    unique case (cfg_chan.index)
      REG_TAP_LEFT:  wr_tap_l = wr_fire;
      REG_TAP_RIGHT: wr_tap_r = wr_fire;
      REG_FB_GAIN:   wr_fb    = wr_fire;
      REG_WET_GAIN:  wr_wet   = wr_fire;
      default: ;
    endcase
  end

  // tap remainder by the line length: reciprocal multiply, back multiply, one correction
  assign quot_prod = PROD_W'(num_r) * PROD_W'(RECIP_K);
  assign back_prod = PROD_W'(quot_r) * PROD_W'(LINE_K);
  assign rest_ext  = CMP_W'(rest_r);
  assign rem_nxt   = (rest_ext >= LINE_K) ? TAP_W'(rest_ext - LINE_K) : rest_r;
  assign last_step = (state_r == CFG_REDUCE) && (cnt_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CFG_IDLE: begin
        if (wr_tap_l || wr_tap_r) begin
          state_nxt = CFG_REDUCE;
        end
      end
      CFG_REDUCE: begin
        if (cnt_r == '0) begin
          state_nxt = CFG_IDLE;
        end
      end
      default: state_nxt = CFG_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cfg_chan.ready = 1'b0;
    busy           = 1'b0;
    unique case (state_r)
      CFG_IDLE:   cfg_chan.ready = 1'b1;
      CFG_REDUCE: busy           = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CFG_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_tap_l || wr_tap_r) begin
        cnt_r <= CNT_W'(RED_STEPS - 1);
      end else if (state_r == CFG_REDUCE) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // reduction operands: quotient estimate, then remainder estimate
  always_ff @(posedge clk) begin
    if (wr_tap_l || wr_tap_r) begin
      num_r       <= cfg_chan.data[TAP_W-1:0];
      dst_right_r <= wr_tap_r;
    end else if (state_r == CFG_REDUCE) begin
      quot_r <= quot_prod[2*TAP_W-1:TAP_W];
      rest_r <= num_r - back_prod[TAP_W-1:0];
    end
  end

  // setting registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_l_r <= TAP_L_RST;
      tap_r_r <= TAP_R_RST;
      fb_r    <= GAIN_W'(FB_GAIN_RST);
      wet_r   <= GAIN_W'(WET_GAIN_RST);
    end else begin
      if (last_step && !dst_right_r) begin
        tap_l_r <= rem_nxt;
      end
      if (last_step && dst_right_r) begin
        tap_r_r <= rem_nxt;
      end
      if (wr_fb) begin
        fb_r <= cfg_chan.data[GAIN_W-1:0];
      end
      if (wr_wet) begin
        wet_r <= cfg_chan.data[GAIN_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_o.tap_left  = tap_l_r;
    cfg_o.tap_right = tap_r_r;
    cfg_o.fb_gain   = fb_r;
    cfg_o.wet_gain  = wet_r;
    cfg_o.busy      = busy;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_ofifo.sv =====
`default_nettype none

module sfd_ofifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sfd_pkg::res_t                    push_i,
  sfd_out_if.source                        out_chan,
  output logic [sfd_pkg::OFIFO_LVL_W-1:0]  level
);
  import sfd_pkg::*;

  localparam int unsigned PTR_W = $clog2(OFIFO_DEPTH);

  sample_t                buf_left_r  [OFIFO_DEPTH];
  sample_t                buf_right_r [OFIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r;
  logic [PTR_W-1:0]       rd_ptr_r;
  logic [OFIFO_LVL_W-1:0] level_r;
  logic [OFIFO_LVL_W-1:0] level_nxt;
  logic                   pop;

  assign pop = out_chan.valid && out_chan.ready;

  always_comb begin
    level_nxt = level_r;
    if (push_i.vld && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (!push_i.vld && pop) begin
      level_nxt = level_r - 1'b1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push_i.vld) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_i.vld) begin
      buf_left_r[wr_ptr_r]  <= push_i.mix_left;
      buf_right_r[wr_ptr_r] <= push_i.mix_right;
    end
  end

  assign out_chan.valid     = (level_r != '0);
  assign out_chan.mix_left  = buf_left_r[rd_ptr_r];
  assign out_chan.mix_right = buf_right_r[rd_ptr_r];
  assign level              = level_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_core.sv =====
`default_nettype none

module sfd_core #(
  parameter  int unsigned LINE_FRAMES = sfd_pkg::LINE_FRAMES_DFLT,
  localparam int unsigned ADDR_W      = (LINE_FRAMES > 1) ? $clog2(LINE_FRAMES) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sfd_in_if.sink                          in_chan,
  input  sfd_pkg::cfg_t                   cfg_i,
  input  logic [sfd_pkg::OFIFO_LVL_W-1:0] fifo_level,
  output sfd_pkg::res_t                   res_o
);
  import sfd_pkg::*;

  localparam logic [ADDR_W:0]   LINE_X  = (ADDR_W + 1)'(LINE_FRAMES);
  localparam logic [ADDR_W-1:0] WP_LAST = ADDR_W'(LINE_FRAMES - 1);

  // read address behind the write pointer, tap already below the line length
  function automatic logic [ADDR_W-1:0] tap_addr(input logic [ADDR_W-1:0] wp,
                                                 input logic [TAP_W-1:0] tap);
    logic [ADDR_W:0] diff;
    diff = {1'b0, wp} - (ADDR_W + 1)'(tap);
    if (diff[ADDR_W]) begin
      diff = diff + LINE_X;
    end
    return diff[ADDR_W-1:0];
  endfunction

  // write pointer and fill tracking
  logic [ADDR_W-1:0] wp_r;
  logic              wrapped_r;

  // stage valids
  logic s1_vld_r, s2_vld_r, s3_vld_r;

  // stage 1: memory data arrives
  sample_t           s1_dry_l_r, s1_dry_r_r;
  logic [ADDR_W-1:0] s1_wp_r;
  logic              s1_fwd_l_r, s1_fwd_r_r;
  sample_t           s1_fwd_dl_r, s1_fwd_dr_r;
  logic              s1_ok_l_r, s1_ok_r_r;

  // stage 2: multiplies
  sample_t           s2_dry_l_r, s2_dry_r_r;
  logic [ADDR_W-1:0] s2_wp_r;
  sample_t           s2_echo_l_r, s2_echo_r_r;
  damp_t             s2_damp_l_r, s2_damp_r_r;

  // stage 3: sums, line write, result
  sample_t                 s3_dry_l_r, s3_dry_r_r;
  logic [ADDR_W-1:0]       s3_wp_r;
  logic [PROD_FB_W-1:0]    s3_fb_l_r, s3_fb_r_r;
  logic [PROD_WET_W-1:0]   s3_wet_l_r, s3_wet_r_r;

  // filter state
  damp_t damp_l_r, damp_r_r;

  logic [ADDR_W-1:0]      rd_l, rd_r;
  logic                   ok_l, ok_r;
  logic                   hit1_l, hit2_l, hit3_l, hit1_r, hit2_r, hit3_r;
  logic                   stall;
  logic [1:0]             inflight;
  logic [OFIFO_LVL_W:0]   level_sum;
  logic                   credit_ok;
  logic                   in_fire;
  sample_t                mem_l_q, mem_r_q;
  sample_t                echo_l, echo_r;
  damp_t                  damp_l_nxt, damp_r_nxt;
  logic signed [GAIN_W:0] fb_s, wet_s;
  logic signed [PROD_FB_W-1:0]  prod_fb_l, prod_fb_r;
  logic signed [PROD_WET_W-1:0] prod_wet_l, prod_wet_r;
  logic signed [SAMPLE_W:0] fb_term_l, fb_term_r, wet_term_l, wet_term_r;
  sample_t                store_l, store_r, mix_l, mix_r;

  // read addresses and whether the entry was written since reset
  assign rd_l = tap_addr(wp_r, cfg_i.tap_left);
  assign rd_r = tap_addr(wp_r, cfg_i.tap_right);
  assign ok_l = wrapped_r || (rd_l < wp_r);
  assign ok_r = wrapped_r || (rd_r < wp_r);

  // pending writes to the entry being read
  assign hit1_l = s1_vld_r && (s1_wp_r == rd_l);
  assign hit2_l = s2_vld_r && (s2_wp_r == rd_l);
  assign hit3_l = s3_vld_r && (s3_wp_r == rd_l);
  assign hit1_r = s1_vld_r && (s1_wp_r == rd_r);
  assign hit2_r = s2_vld_r && (s2_wp_r == rd_r);
  assign hit3_r = s3_vld_r && (s3_wp_r == rd_r);
  assign stall  = hit1_l || hit2_l || hit1_r || hit2_r;

  // room in the output queue for everything in flight
  assign inflight  = 2'(s1_vld_r) + 2'(s2_vld_r) + 2'(s3_vld_r);
  assign level_sum = (OFIFO_LVL_W + 1)'(fifo_level) + (OFIFO_LVL_W + 1)'(inflight);
  assign credit_ok = level_sum < (OFIFO_LVL_W + 1)'(OFIFO_DEPTH);

  assign in_chan.ready = credit_ok && !stall && !cfg_i.busy;
  assign in_fire       = in_chan.valid && in_chan.ready;

  sfd_line #(.DEPTH(LINE_FRAMES), .WIDTH(SAMPLE_W)) u_line_left (
    .clk     (clk),
    .wr_en   (s3_vld_r),
    .wr_addr (s3_wp_r),
    .wr_data (store_l),
    .rd_en   (in_fire),
    .rd_addr (rd_l),
    .rd_data (mem_l_q)
  );

  sfd_line #(.DEPTH(LINE_FRAMES), .WIDTH(SAMPLE_W)) u_line_right (
    .clk     (clk),
    .wr_en   (s3_vld_r),
    .wr_addr (s3_wp_r),
    .wr_data (store_r),
    .rd_en   (in_fire),
    .rd_addr (rd_r),
    .rd_data (mem_r_q)
  );

  // control: pointer and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (in_fire) begin
        if (wp_r == WP_LAST) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
    end
  end

  // stage 1 capture, with the store being written this cycle forwarded
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_dry_l_r  <= in_chan.dry_left;
      s1_dry_r_r  <= in_chan.dry_right;
      s1_wp_r     <= wp_r;
      s1_fwd_l_r  <= hit3_l;
      s1_fwd_r_r  <= hit3_r;
      s1_fwd_dl_r <= store_l;
      s1_fwd_dr_r <= store_r;
      s1_ok_l_r   <= ok_l;
      s1_ok_r_r   <= ok_r;
    end
  end

  // echo select and filter update
  assign echo_l     = s1_fwd_l_r ? s1_fwd_dl_r : (s1_ok_l_r ? mem_l_q : '0);
  assign echo_r     = s1_fwd_r_r ? s1_fwd_dr_r : (s1_ok_r_r ? mem_r_q : '0);
  assign damp_l_nxt = damp_step(damp_l_r, echo_l);
  assign damp_r_nxt = damp_step(damp_r_r, echo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_l_r <= '0;
      damp_r_r <= '0;
    end else if (s1_vld_r) begin
      damp_l_r <= damp_l_nxt;
      damp_r_r <= damp_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_dry_l_r  <= s1_dry_l_r;
      s2_dry_r_r  <= s1_dry_r_r;
      s2_wp_r     <= s1_wp_r;
      s2_echo_l_r <= echo_l;
      s2_echo_r_r <= echo_r;
      s2_damp_l_r <= damp_l_nxt;
      s2_damp_r_r <= damp_r_nxt;
    end
  end

  // gain products, cross feedback takes the other channel's filter
  assign fb_s       = {1'b0, cfg_i.fb_gain};
  assign wet_s      = {1'b0, cfg_i.wet_gain};
  assign prod_fb_l  = s2_damp_r_r * fb_s;
  assign prod_fb_r  = s2_damp_l_r * fb_s;
  assign prod_wet_l = s2_echo_l_r * wet_s;
  assign prod_wet_r = s2_echo_r_r * wet_s;

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      s3_dry_l_r <= s2_dry_l_r;
      s3_dry_r_r <= s2_dry_r_r;
      s3_wp_r    <= s2_wp_r;
      s3_fb_l_r  <= prod_fb_l;
      s3_fb_r_r  <= prod_fb_r;
      s3_wet_l_r <= prod_wet_l;
      s3_wet_r_r <= prod_wet_r;
    end
  end

  // floor shifts, dry add and saturation
  assign fb_term_l  = s3_fb_l_r[PROD_FB_W-1:FB_SHIFT];
  assign fb_term_r  = s3_fb_r_r[PROD_FB_W-1:FB_SHIFT];
  assign wet_term_l = s3_wet_l_r[PROD_WET_W-1:WET_SHIFT];
  assign wet_term_r = s3_wet_r_r[PROD_WET_W-1:WET_SHIFT];

  assign store_l = sat_sample(SUM_W'(s3_dry_l_r) + SUM_W'(fb_term_l));
  assign store_r = sat_sample(SUM_W'(s3_dry_r_r) + SUM_W'(fb_term_r));
  assign mix_l   = sat_sample(SUM_W'(s3_dry_l_r) + SUM_W'(wet_term_l));
  assign mix_r   = sat_sample(SUM_W'(s3_dry_r_r) + SUM_W'(wet_term_r));

  always_comb begin
    res_o.vld       = s3_vld_r;
    res_o.mix_left  = mix_l;
    res_o.mix_right = mix_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stereo_cross_feedback_delay_unit.sv =====
// path: a frame accepted on in_chan passes stages 1 to 3 and the output queue before it is offered on out_chan
// throughput: one frame per cycle while the output queue has room, one read and one write per line
//   memory per cycle; a tap of 1 or 2 frames (modulo the line length) waits on the pending line write,
//   and a tap write holds cfg and input while the tap is being reduced
// reset: settings to defaults, filters, pointer and output queue cleared; line entries
//   not written since reset read as zero through fill tracking, no clearing pass
`default_nettype none

`include "assert_macros.svh"

module stereo_cross_feedback_delay_unit #(
  parameter int unsigned LINE_FRAMES = sfd_pkg::LINE_FRAMES_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  sfd_in_if.sink    in_chan,
  sfd_out_if.source out_chan,
  sfd_cfg_if.sink   cfg_chan
);
  import sfd_pkg::*;

  cfg_t                   cfg;
  res_t                   res;
  logic [OFIFO_LVL_W-1:0] fifo_level;

  sfd_cfg #(.LINE_FRAMES(LINE_FRAMES)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  sfd_core #(.LINE_FRAMES(LINE_FRAMES)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_i      (cfg),
    .fifo_level (fifo_level),
    .res_o      (res)
  );

  sfd_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (res),
    .out_chan (out_chan),
    .level    (fifo_level)
  );

  // every accepted transaction reaches the output queue after the pipeline
  `SFD_ASSERT_DELAY(a_frame_reaches_queue, in_chan.valid && in_chan.ready, 3, res.vld, "accepted frame lost in pipeline")

  // credit check keeps the output queue from overflowing
  `SFD_ASSERT_IMPL(a_queue_no_overflow, res.vld, 32'(fifo_level) < OFIFO_DEPTH, "push into full output queue")

  // no frame enters while a tap is being reduced
  `SFD_ASSERT_IMPL(a_no_input_while_busy, cfg.busy, !(in_chan.valid && in_chan.ready), "frame accepted during tap reduction")

  // reduced taps always address inside the line
  `SFD_ASSERT_IMPL(a_tap_in_line, !cfg.busy, (32'(cfg.tap_left) < LINE_FRAMES) && (32'(cfg.tap_right) < LINE_FRAMES), "tap not reduced below line length")

endmodule

`default_nettype wire

// ===== verif/sfd_checker.sv =====
`timescale 1ns / 100ps

module sfd_checker (
  input  logic clk,
  input  logic rst_n,
  sfd_in_if    in_mon,
  sfd_out_if   out_mon,
  sfd_cfg_if   cfg_mon,
  output int   fail_count,
  output int   awaiting
);
  import sfd_pkg::*;

  localparam int unsigned LINE = LINE_FRAMES_DFLT;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } mix_frame_t;

  // live settings as seen by the datapath
  logic [TAP_W-1:0]  tap_left_q;
  logic [TAP_W-1:0]  tap_right_q;
  logic [GAIN_W-1:0] fb_gain_q;
  logic [GAIN_W-1:0] wet_gain_q;

  // delay lines, shared write position and damped echoes
  sample_t     left_hist [LINE];
  sample_t     right_hist [LINE];
  int unsigned wr_pos;
  longint      left_lp;
  longint      right_lp;

  mix_frame_t  mix_expect [$];

  function automatic sample_t clamp_sample(input longint x);
    longint top_val;
    longint bottom_val;
    top_val    = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    bottom_val = -top_val - 1;
    if (x > top_val) begin
      return sample_t'(top_val);
    end
    if (x < bottom_val) begin
      return sample_t'(bottom_val);
    end
    return sample_t'(x);
  endfunction

  // one frame through the echo network, expected mix queued
  task automatic predict_mix(input sample_t dl, input sample_t dr);
    int unsigned li;
    int unsigned ri;
    longint      el;
    longint      er;
    longint      stl;
    longint      str;
    mix_frame_t  f;
    li = (wr_pos + LINE - (tap_left_q % LINE)) % LINE;
    ri = (wr_pos + LINE - (tap_right_q % LINE)) % LINE;
    el = left_hist[li];
    er = right_hist[ri];
    // quarter-coefficient lowpass, floor rounding
    left_lp  = left_lp + el + ((-left_lp) >>> 2);
    right_lp = right_lp + er + ((-right_lp) >>> 2);
    // cross feedback into the opposite line
    stl = longint'(dl) + ((right_lp * longint'(fb_gain_q)) >>> FB_SHIFT);
    str = longint'(dr) + ((left_lp * longint'(fb_gain_q)) >>> FB_SHIFT);
    left_hist[wr_pos]  = clamp_sample(stl);
    right_hist[wr_pos] = clamp_sample(str);
    wr_pos = (wr_pos + 1) % LINE;
    // dry plus unfiltered echo at wet level
    f.left  = clamp_sample(longint'(dl) + ((el * longint'(wet_gain_q)) >>> WET_SHIFT));
    f.right = clamp_sample(longint'(dr) + ((er * longint'(wet_gain_q)) >>> WET_SHIFT));
    mix_expect.insert(mix_expect.size(), f);
  endtask

  // compare one output transaction with the oldest expectation
  task automatic check_mix(input sample_t got_l, input sample_t got_r);
    mix_frame_t f;
    if (mix_expect.size() == 0) begin
      $display("%0t unexpected mix frame: left %0d right %0d", $time, got_l, got_r);
      fail_count++;
    end else begin
      f = mix_expect.pop_front();
      if (f.left !== got_l) begin
        $display("%0t mix_left mismatch: expected %0d, actual %0d", $time, f.left, got_l);
        fail_count++;
      end
      if (f.right !== got_r) begin
        $display("%0t mix_right mismatch: expected %0d, actual %0d", $time, f.right, got_r);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tap_left_q  = TAP_W'(TAP_LEFT_RST);
      tap_right_q = TAP_W'(TAP_RIGHT_RST);
      fb_gain_q   = GAIN_W'(FB_GAIN_RST);
      wet_gain_q  = GAIN_W'(WET_GAIN_RST);
      for (int i = 0; i < LINE; i++) begin
        left_hist[i]  = '0;
        right_hist[i] = '0;
      end
      wr_pos   = 0;
      left_lp  = 0;
      right_lp = 0;
      mix_expect.delete();
      fail_count = 0;
      awaiting <= 0;
    end else begin
      // results first: no frame can leave in the cycle it enters
      if (out_mon.valid && out_mon.ready) begin
        check_mix(out_mon.mix_left, out_mon.mix_right);
      end
      // register writes, masked to width, unknown indexes dropped
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_TAP_LEFT:  tap_left_q  = cfg_mon.data[TAP_W-1:0];
          REG_TAP_RIGHT: tap_right_q = cfg_mon.data[TAP_W-1:0];
          REG_FB_GAIN:   fb_gain_q   = cfg_mon.data[GAIN_W-1:0];
          REG_WET_GAIN:  wet_gain_q  = cfg_mon.data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_mix(in_mon.dry_left, in_mon.dry_right);
      end
      awaiting <= mix_expect.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sfd_pkg::*;

  localparam int PHASES        = 12;
  localparam int PHASE_FRAMES  = 112;
  localparam int CORNERS       = 12;
  localparam int STALL_CYCLES  = 80;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 8;
  localparam int IDLE_PERCENT  = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX = '1;

  logic clk;
  logic rst_n;
  logic calm;
  logic stall_req;
  logic stall_done;
  int   hold_cnt;
  int   fail_count;
  int   awaiting;
  int   drain_cnt;

  sfd_in_if  in_chan ();
  sfd_out_if out_chan ();
  sfd_cfg_if cfg_chan ();

  // corner frames: full scale, sign flips, alternating bits
  sample_t corner_left [CORNERS] = '{
    16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd1,
    16'sd1, 16'sh5555, 16'shAAAA, 16'sd0, -16'sd32768, 16'sd0
  };
  sample_t corner_right [CORNERS] = '{
    16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd1,
    -16'sd1, 16'shAAAA, 16'sh5555, 16'sd32767, 16'sd0, 16'sd0
  };

  stereo_cross_feedback_delay_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  sfd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_cnt       <= 0;
      stall_done     <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_chan.ready <= 1'b0;
      hold_cnt       <= hold_cnt - 1;
    end else if (stall_req && !stall_done) begin
      out_chan.ready <= 1'b0;
      hold_cnt       <= STALL_CYCLES;
      stall_done     <= 1'b1;
    end else begin
      out_chan.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic sample_t pick_sample();
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0:       return 16'sd32767;
        1:       return -16'sd32768;
        2:       return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return sample_t'($urandom_range(65535, 0));
  endfunction

  // mostly short taps so echoes build up, some zero and out-of-range
  function automatic logic [CFG_DATA_W-1:0] pick_tap();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return CFG_DATA_W'($urandom_range(40, 1));
    end else if (r < 75) begin
      return CFG_DATA_W'($urandom_range(2, 0));
    end else if (r < 90) begin
      return CFG_DATA_W'($urandom_range(LINE_FRAMES_DFLT - 1, 1));
    end
    return CFG_DATA_W'($urandom_range(65535, 0));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    if ($urandom_range(99) < 30) begin
      return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    return CFG_DATA_W'($urandom_range(65535, 0));
  endfunction

  // one input transaction, valid stays up for a following frame
  task automatic send_frame(input sample_t l, input sample_t r);
    if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_chan.valid     <= 1'b1;
    in_chan.dry_left  <= l;
    in_chan.dry_right <= r;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // stop offering and wait for every outstanding mix frame
  task automatic drain_mix();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // settings per phase: extremes first, then random
  task automatic configure(input int p);
    case (p)
      0: begin
        write_reg(REG_TAP_LEFT, 16'd1);
        write_reg(REG_TAP_RIGHT, 16'd2);
        write_reg(REG_FB_GAIN, 16'hFFFF);
        write_reg(REG_WET_GAIN, 16'hFFFF);
      end
      1: begin
        write_reg(REG_TAP_LEFT, 16'd0);
        write_reg(REG_TAP_RIGHT, CFG_DATA_W'(LINE_FRAMES_DFLT));
        write_reg(REG_FB_GAIN, 16'h0000);
        write_reg(REG_WET_GAIN, 16'h0000);
      end
      2: begin
        write_reg(REG_TAP_LEFT, CFG_DATA_W'(LINE_FRAMES_DFLT - 1));
        write_reg(REG_TAP_RIGHT, 16'hFFFF);
        write_reg(REG_FB_GAIN, 16'hFFFF);
        write_reg(REG_WET_GAIN, 16'h0000);
        write_reg(REG_BEYOND, pick_gain());
        write_reg(REG_TOP_IDX, pick_gain());
      end
      default: begin
        write_reg(REG_TAP_LEFT, pick_tap());
        write_reg(REG_TAP_RIGHT, pick_tap());
        write_reg(REG_FB_GAIN, pick_gain());
        write_reg(REG_WET_GAIN, pick_gain());
      end
    endcase
  endtask

  initial begin
    rst_n             <= 1'b0;
    calm              <= 1'b0;
    stall_req         <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.dry_left  <= '0;
    in_chan.dry_right <= '0;
    cfg_chan.valid    <= 1'b0;
    cfg_chan.index    <= '0;
    cfg_chan.data     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // corner frames at reset settings
    for (int i = 0; i < CORNERS; i++) begin
      send_frame(corner_left[i], corner_right[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_mix();
      configure(p);
      calm <= (p == 4);
      // corner frames again with short taps and full gains
      if (p == 0) begin
        for (int i = 0; i < CORNERS; i++) begin
          send_frame(corner_left[i], corner_right[i]);
        end
      end
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if (p == 5 && n == 20) begin
          stall_req <= 1'b1;
        end
        if (p == 6 && n == 50) begin
          drain_mix();
        end
        send_frame(pick_sample(), pick_sample());
      end
    end

    // final drain, bounded
    in_chan.valid <= 1'b0;
    drain_cnt = 0;
    do begin
      @(posedge clk);
      drain_cnt++;
    end while (awaiting != 0 && drain_cnt < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (awaiting == 0 && fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
